/* design/ntp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_pkg: shared definitions for the nearest three points search
// Sizes of the point store, the ranked list and the arithmetic words, the
// command codes and the sequencer states.
// ----------------------------------------------------------------------------
package ntp_pkg;

  localparam int MAX_POINTS    = 64;
  localparam int NEAREST_COUNT = 3;

  localparam int COORD_W = 16;
  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int USED_W  = $clog2(NEAREST_COUNT + 1);
  localparam int KIDX_W  = (NEAREST_COUNT > 1) ? $clog2(NEAREST_COUNT) : 1;

  // Magnitude of a coordinate difference, its square and the sum of two.
  localparam int ABS_W  = COORD_W;
  localparam int PROD_W = 2 * ABS_W;
  localparam int D2_W   = PROD_W + 1;

  // The distance is floor(sqrt(d2 << 16)): 8 fractional bits.
  localparam int FRAC_BITS = 8;
  localparam int DIST_W    = 25;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_LOAD  = 2'd1,
    FN_QUERY = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MULX,
    ST_MULY,
    ST_INS,
    ST_FETCH,
    ST_ROOT,
    ST_EMIT
  } state_t;

endpackage

/* design/nearest_three_points_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_three_points_top: three nearest neighbor search over a point store
// Holds up to 64 signed 2-D points and reports the three nearest to a query
// point with their Euclidean distances.
// ----------------------------------------------------------------------------
// A clear word empties the store and a load word appends one point; after
// either the block is ready again at once (a load into a full store is
// dropped). A query word makes the block busy (in_stall high) while it scans
// the store: each stored point goes through the RAM read, a difference stage
// and two passes of the single 16x16 multiplier, then the ranked list insert.
// Then, for each of up to three results, the point is fetched from the RAM
// and the distance goes through the bit-serial square root unit. Results are
// ranked on the exact squared distance, ties going to the point loaded
// first. The distance is floor(256 * sqrt(dx^2 + dy^2)), and out_last marks
// the final word of each query. A query on an empty store yields no word.
// The output word sits in its own register, so the block takes new input
// words while the last result of a query is still stalled.
// ----------------------------------------------------------------------------
module nearest_three_points_top (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_near_x,
  output logic signed [15:0] out_near_y,
  output logic [24:0] out_distance,
  output logic        out_last
);

  localparam int CW  = ntp_pkg::COORD_W;
  localparam int AW  = ntp_pkg::ADDR_W;
  localparam int NW  = ntp_pkg::CNT_W;
  localparam int UW  = ntp_pkg::USED_W;
  localparam int KW  = ntp_pkg::KIDX_W;
  localparam int NK  = ntp_pkg::NEAREST_COUNT;
  localparam int XW  = ntp_pkg::ABS_W;
  localparam int PW  = ntp_pkg::PROD_W;
  localparam int DW  = ntp_pkg::D2_W;
  localparam int RW  = ntp_pkg::DIST_W;

  ntp_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]   count_r, count_nxt;
  logic [NW-1:0]   scan_r, scan_nxt;
  logic [CW-1:0]   ref_x_r, ref_x_nxt;
  logic [CW-1:0]   ref_y_r, ref_y_nxt;
  logic [XW-1:0]   ax_r, ax_nxt;
  logic [XW-1:0]   ay_r, ay_nxt;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [DW-1:0]   d2_r, d2_nxt;
  logic [DW-1:0]   best_d2_r  [NK];
  logic [DW-1:0]   best_d2_nxt[NK];
  logic [AW-1:0]   best_idx_r [NK];
  logic [AW-1:0]   best_idx_nxt[NK];
  logic [UW-1:0]   used_r, used_nxt;
  logic [KW-1:0]   outk_r, outk_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [CW-1:0]   out_x_r, out_x_nxt;
  logic [CW-1:0]   out_y_r, out_y_nxt;
  logic [RW-1:0]   out_d_r, out_d_nxt;
  logic            out_last_r, out_last_nxt;

  // RAM and shared units
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [2*CW-1:0] ram_rdata;

  logic [XW-1:0]   mul_op;
  logic [PW-1:0]   mul_out;

  logic            sq_start;
  logic            sq_done;
  logic [RW-1:0]   sq_root;

  logic            in_acc;
  logic            out_free;
  logic [CW:0]     dx, dy;
  logic [NK-1:0]   keep;

  assign in_stall = (state_r != ntp_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  ntp_ram #(
    .WIDTH(2 * CW),
    .DEPTH(ntp_pkg::MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({in_coord_x, in_coord_y}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ntp_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .d2   (best_d2_r[outk_r]),
    .done (sq_done),
    .root (sq_root)
  );

  // Loads append at the fill count; the store is never read past it.
  assign ram_we    = in_acc && (in_func == ntp_pkg::FN_LOAD) &&
                     (count_r < NW'(ntp_pkg::MAX_POINTS));
  assign ram_waddr = count_r[AW-1:0];
  assign ram_re    = (state_r == ntp_pkg::ST_READ) || (state_r == ntp_pkg::ST_FETCH);
  assign ram_raddr = (state_r == ntp_pkg::ST_READ) ? scan_r[AW-1:0] : best_idx_r[outk_r];
  assign sq_start  = (state_r == ntp_pkg::ST_FETCH);

  // The one multiplier squares x magnitude first, then y magnitude.
  assign mul_op  = (state_r == ntp_pkg::ST_MULX) ? ax_r : ay_r;
  assign mul_out = mul_op * mul_op;

  // Differences to the reference, with one extra bit.
  assign dx = {ram_rdata[2*CW-1], ram_rdata[2*CW-1:CW]} - {ref_x_r[CW-1], ref_x_r};
  assign dy = {ram_rdata[CW-1], ram_rdata[CW-1:0]} - {ref_y_r[CW-1], ref_y_r};

  // An entry stays where it is if it is in use and not strictly farther than
  // the new point; those entries form a prefix of the sorted list.
  always_comb begin
    for (int k = 0; k < NK; k++) begin
      keep[k] = (UW'(k) < used_r) && !(d2_r < best_d2_r[k]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    ref_x_nxt     = ref_x_r;
    ref_y_nxt     = ref_y_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    prod_nxt      = prod_r;
    d2_nxt        = d2_r;
    used_nxt      = used_r;
    outk_nxt      = outk_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_d_nxt     = out_d_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int k = 0; k < NK; k++) begin
      best_d2_nxt[k]  = best_d2_r[k];
      best_idx_nxt[k] = best_idx_r[k];
    end

    unique case (state_r)
      ntp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_func == ntp_pkg::FN_CLEAR) begin
            count_nxt = '0;
          end else if (in_func == ntp_pkg::FN_LOAD) begin
            if (count_r < NW'(ntp_pkg::MAX_POINTS)) begin
              count_nxt = count_r + NW'(1);
            end
          end else if (in_func == ntp_pkg::FN_QUERY) begin
            ref_x_nxt = in_coord_x;
            ref_y_nxt = in_coord_y;
            scan_nxt  = '0;
            used_nxt  = '0;
            if (count_r != '0) begin
              state_nxt = ntp_pkg::ST_READ;
            end
          end
        end
      end
      ntp_pkg::ST_READ: begin
        state_nxt = ntp_pkg::ST_DIFF;
      end
      ntp_pkg::ST_DIFF: begin
        ax_nxt    = dx[CW] ? XW'(-dx) : XW'(dx);
        ay_nxt    = dy[CW] ? XW'(-dy) : XW'(dy);
        state_nxt = ntp_pkg::ST_MULX;
      end
      ntp_pkg::ST_MULX: begin
        prod_nxt  = mul_out;
        state_nxt = ntp_pkg::ST_MULY;
      end
      ntp_pkg::ST_MULY: begin
        d2_nxt    = {1'b0, prod_r} + {1'b0, mul_out};
        state_nxt = ntp_pkg::ST_INS;
      end
      ntp_pkg::ST_INS: begin
        // Insert behind the kept prefix and push the rest down one place.
        for (int k = 0; k < NK; k++) begin
          if (!keep[k]) begin
            if (k == 0 || keep[(k == 0) ? 0 : k - 1]) begin
              best_d2_nxt[k]  = d2_r;
              best_idx_nxt[k] = scan_r[AW-1:0];
            end else begin
              best_d2_nxt[k]  = best_d2_r[(k == 0) ? 0 : k - 1];
              best_idx_nxt[k] = best_idx_r[(k == 0) ? 0 : k - 1];
            end
          end
        end
        if (!keep[NK-1] && used_r != UW'(NK)) begin
          used_nxt = used_r + UW'(1);
        end
        scan_nxt = scan_r + NW'(1);
        if (scan_r + NW'(1) == count_r) begin
          outk_nxt  = '0;
          state_nxt = ntp_pkg::ST_FETCH;
        end else begin
          state_nxt = ntp_pkg::ST_READ;
        end
      end
      ntp_pkg::ST_FETCH: begin
        state_nxt = ntp_pkg::ST_ROOT;
      end
      ntp_pkg::ST_ROOT: begin
        if (sq_done) begin
          state_nxt = ntp_pkg::ST_EMIT;
        end
      end
      ntp_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = ram_rdata[2*CW-1:CW];
          out_y_nxt     = ram_rdata[CW-1:0];
          out_d_nxt     = sq_root;
          out_last_nxt  = (UW'(outk_r) + UW'(1) == used_r);
          if (UW'(outk_r) + UW'(1) == used_r) begin
            state_nxt = ntp_pkg::ST_IDLE;
          end else begin
            outk_nxt  = outk_r + KW'(1);
            state_nxt = ntp_pkg::ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ntp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ntp_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r     <= scan_nxt;
    ref_x_r    <= ref_x_nxt;
    ref_y_r    <= ref_y_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    prod_r     <= prod_nxt;
    d2_r       <= d2_nxt;
    used_r     <= used_nxt;
    outk_r     <= outk_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_d_r    <= out_d_nxt;
    out_last_r <= out_last_nxt;
    for (int k = 0; k < NK; k++) begin
      best_d2_r[k]  <= best_d2_nxt[k];
      best_idx_r[k] <= best_idx_nxt[k];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_near_x   = out_x_r;
  assign out_near_y   = out_y_r;
  assign out_distance = out_d_r;
  assign out_last     = out_last_r;

endmodule

/* design/ntp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module ntp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/ntp_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_isqrt: iterative integer square root
// Returns floor(sqrt(d2 * 2^16)), one result bit per cycle, using the
// digit-by-digit method on a shared compare and subtract.
// ----------------------------------------------------------------------------
module ntp_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ntp_pkg::D2_W-1:0]  d2,
  output logic                      done,
  output logic [ntp_pkg::DIST_W-1:0] root
);

  localparam int RT_W   = ntp_pkg::DIST_W;
  localparam int RAD_W  = 2 * RT_W;
  localparam int REM_W  = RT_W + 3;
  localparam int STEP_W = $clog2(RT_W);

  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [RT_W-1:0]   root_r, root_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // The partial remainder never exceeds twice the partial root, so the two
  // bits dropped by the shift are always zero.
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = RAD_W'({d2, {(2 * ntp_pkg::FRAC_BITS){1'b0}}});
      rem_nxt  = '0;
      root_nxt = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RT_W-2:0], 1'b0};
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(RT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* dv/tb_nearest_three_points_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_three_points_top: self-checking bench for the nearest point search
// Drives clear, load and query words with random idling on both channels and
// checks every result word against a behavioral ranking or a fixed table row.
// ----------------------------------------------------------------------------
module tb_nearest_three_points_top;

  localparam int COORD_W       = ntp_pkg::COORD_W;
  localparam int DIST_W        = ntp_pkg::DIST_W;
  localparam int MAX_POINTS    = ntp_pkg::MAX_POINTS;
  localparam int NEAREST_COUNT = ntp_pkg::NEAREST_COUNT;

  // The command field has one code the block does not use; it must be ignored.
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam int ITEMS          = 220;
  localparam int TAIL_ITEMS     = 30;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_MAX     = 10;

  // Ways of picking coordinates for one sequence of words.
  localparam int COORD_FULL    = 0;
  localparam int COORD_CLUSTER = 1;
  localparam int COORD_EDGE    = 2;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_func;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] out_near_x;
  logic signed [COORD_W-1:0] out_near_y;
  logic [DIST_W-1:0]         out_distance;
  logic                      out_last;

  // One result word as the block should present it.
  typedef struct {
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic [DIST_W-1:0]         distance;
    logic                      last;
  } near_word_t;

  // One row of the directed table. Rows marked fixed carry their expected
  // result written out by hand; all other rows are ranked by the bench.
  typedef struct {
    logic [1:0]                fn;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    bit                        fixed;
    int                        fixed_count;
    logic signed [COORD_W-1:0] ex_x;
    logic signed [COORD_W-1:0] ex_y;
    logic [DIST_W-1:0]         ex_dist;
  } plan_row_t;

  // Behavioral copy of the point store.
  logic signed [COORD_W-1:0] stored_x [MAX_POINTS];
  logic signed [COORD_W-1:0] stored_y [MAX_POINTS];
  int unsigned               stored_n;

  near_word_t nearest_q [$];
  plan_row_t  plan [$];

  int  fail_count;
  int  counted;
  bit  quiet_tail;
  bit  no_gaps;
  bit  hold_start;
  bit  timed_out;

  nearest_three_points_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_coord_x   (in_coord_x),
    .in_coord_y   (in_coord_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_near_x   (out_near_x),
    .out_near_y   (out_near_y),
    .out_distance (out_distance),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, rounded down, by the classic two-bits-per-step method.
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Applies one accepted word to the store copy. For a query it ranks the
  // stored points on exact squared distance and, when rank_out is set,
  // queues the words the block must produce. A strict compare keeps the
  // earlier loaded point ahead on a tie.
  task automatic apply_command(input logic [1:0] fn, input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y, input bit rank_out);
    int unsigned     rank_idx [NEAREST_COUNT];
    longint unsigned rank_d2 [NEAREST_COUNT];
    int unsigned     used;
    int unsigned     pos;
    int unsigned     k;
    int unsigned     i;
    longint signed   dx;
    longint signed   dy;
    longint unsigned d2;
    longint unsigned root;
    near_word_t      w;
    case (fn)
      ntp_pkg::FN_CLEAR: stored_n = 0;
      ntp_pkg::FN_LOAD: begin
        if (stored_n < MAX_POINTS) begin
          stored_x[stored_n] = x;
          stored_y[stored_n] = y;
          stored_n++;
        end
      end
      ntp_pkg::FN_QUERY: begin
        used = 0;
        for (i = 0; i < stored_n; i++) begin
          dx  = longint'(stored_x[i]) - longint'(x);
          dy  = longint'(stored_y[i]) - longint'(y);
          d2  = longint'(dx * dx + dy * dy);
          pos = used;
          while (pos > 0 && d2 < rank_d2[pos-1]) pos--;
          if (pos < NEAREST_COUNT) begin
            k = (used < NEAREST_COUNT) ? used : NEAREST_COUNT - 1;
            while (k > pos) begin
              rank_d2[k]  = rank_d2[k-1];
              rank_idx[k] = rank_idx[k-1];
              k--;
            end
            rank_d2[pos]  = d2;
            rank_idx[pos] = i;
            if (used < NEAREST_COUNT) used++;
          end
        end
        if (rank_out) begin
          for (k = 0; k < used; k++) begin
            root       = floor_sqrt(rank_d2[k] << 16);
            w.near_x   = stored_x[rank_idx[k]];
            w.near_y   = stored_y[rank_idx[k]];
            w.distance = root[DIST_W-1:0];
            w.last     = (k + 1 == used);
            nearest_q.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offers one command word and holds it until the block takes it. A random
  // gap of idle cycles may come first, except in bursts and near the end.
  // Words the block ignores (the unused code, a load into a full store) are
  // not counted toward the item total.
  task automatic send_word(input logic [1:0] fn, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y, input bit rank_out);
    if (!no_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= fn;
    in_coord_x <= x;
    in_coord_y <= y;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (fn != FN_UNUSED && !(fn == ntp_pkg::FN_LOAD && stored_n >= MAX_POINTS)) counted++;
    if (counted >= ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
    apply_command(fn, x, y, rank_out);
  endtask

  // Stops offering words until every expected result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (nearest_q.size() != 0);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(input int mode, input int center);
    int v;
    case (mode)
      COORD_FULL:    v = int'($urandom_range(0, 65535)) - 32768;
      COORD_CLUSTER: v = center + int'($urandom_range(0, 4)) - 2;
      default: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v[COORD_W-1:0];
  endfunction

  function automatic void add_row(input logic [1:0] fn, input int x, input int y,
                                  input bit fixed, input int fixed_count,
                                  input int ex_x, input int ex_y, input int ex_dist);
    plan_row_t r;
    r.fn          = fn;
    r.x           = x[COORD_W-1:0];
    r.y           = y[COORD_W-1:0];
    r.fixed       = fixed;
    r.fixed_count = fixed_count;
    r.ex_x        = ex_x[COORD_W-1:0];
    r.ex_y        = ex_y[COORD_W-1:0];
    r.ex_dist     = ex_dist[DIST_W-1:0];
    plan.push_back(r);
  endfunction

  // The receiver stalls in short random bursts. When the sender raises
  // hold_start it instead stalls without a break, so that the output
  // register fills and the block has to stall its input. In the tail of the
  // run it starts no new stalls.
  initial begin : result_stall
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_left  = LONG_HOLD;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result word is matched against the oldest expected one.
  initial begin : result_check
    near_word_t want;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (nearest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result word: x=%0d y=%0d dist=%0d last=%0b",
                     out_near_x, out_near_y, out_distance, out_last);
        end else begin
          want = nearest_q.pop_front();
          if (out_near_x !== want.near_x || out_near_y !== want.near_y ||
              out_distance !== want.distance || out_last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("mismatch: want x=%0d y=%0d d=%0d l=%0b, got x=%0d y=%0d d=%0d l=%0b",
                       want.near_x, want.near_y, want.distance, want.last,
                       out_near_x, out_near_y, out_distance, out_last);
          end
        end
      end
    end
  end

  // Watchdog: any cycle in which neither channel moves a word counts toward
  // the limit. The longest legal quiet stretch is a full-store query under a
  // long receiver hold, well below the limit.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    timed_out = 1'b1;
    $display("tb_nearest_three_points_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int seq_no;
    int mode;
    int center;
    int idx;
    near_word_t w;
    fail_count = 0;
    counted    = 0;
    quiet_tail = 1'b0;
    no_gaps    = 1'b0;
    hold_start = 1'b0;
    timed_out  = 1'b0;
    stored_n   = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_func    <= ntp_pkg::FN_CLEAR;
    in_coord_x <= '0;
    in_coord_y <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A query on an empty store must give no word at all; a
    // single point at the far corner gives the largest possible distance,
    // and the same point queried on itself gives zero. The middle rows set
    // up ties (a duplicate point and two points at the same range) and the
    // unused command code, and are ranked by the bench.
    add_row(ntp_pkg::FN_QUERY,       0,      0, 1, 0,      0,      0,        0);
    add_row(FN_UNUSED,           32767,     -1, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_LOAD,   -32768, -32768, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_QUERY,   32767,  32767, 1, 1, -32768, -32768, 23726204);
    add_row(ntp_pkg::FN_QUERY,  -32768, -32768, 1, 1, -32768, -32768,        0);
    add_row(ntp_pkg::FN_CLEAR,       0,      0, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_QUERY,     100,   -100, 1, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_LOAD,        0,      0, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_LOAD,        3,      4, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_QUERY,       0,      0, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_LOAD,       -3,     -4, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_LOAD,        0,      0, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_QUERY,       0,      0, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_LOAD,    32767, -32768, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_QUERY,       1,      1, 0, 0,      0,      0,        0);
    add_row(FN_UNUSED,          -32768,  32767, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_QUERY,   32767, -32768, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_QUERY,      -1,     -1, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_CLEAR,      -1,     -1, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_LOAD,        5,     -7, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_QUERY,  -32768,  32767, 0, 0,      0,      0,        0);
    add_row(ntp_pkg::FN_QUERY,       5,     -7, 1, 1,      5,     -7,        0);

    foreach (plan[i]) begin
      send_word(plan[i].fn, plan[i].x, plan[i].y, !plan[i].fixed);
      if (plan[i].fixed && plan[i].fixed_count == 1) begin
        w.near_x   = plan[i].ex_x;
        w.near_y   = plan[i].ex_y;
        w.distance = plan[i].ex_dist;
        w.last     = 1'b1;
        nearest_q.push_back(w);
      end
    end

    // Random part, built from short sequences: maybe a clear, a few loads,
    // maybe an unused code word, then one to three queries. Each sequence
    // picks its coordinates in one way: full range, a tight cluster (so that
    // ties are common) or the values -32768, 32767, 0 and -1.
    seq_no = 0;
    while (counted < ITEMS) begin
      seq_no++;
      idx = $urandom_range(0, 19);
      mode = (idx < 10) ? COORD_FULL : (idx < 17) ? COORD_CLUSTER : COORD_EDGE;
      center = int'($urandom_range(0, 2000)) - 1000;
      if (seq_no == 3) begin
        // Back-to-back words against a receiver that holds off for a long
        // stretch, so that the block backs up to its input.
        hold_start = 1'b1;
        no_gaps    = 1'b1;
        send_word(ntp_pkg::FN_CLEAR, pick_coord(mode, center), pick_coord(mode, center), 1'b1);
        repeat (6)
          send_word(ntp_pkg::FN_LOAD, pick_coord(mode, center), pick_coord(mode, center), 1'b1);
        repeat (4)
          send_word(ntp_pkg::FN_QUERY, pick_coord(mode, center), pick_coord(mode, center), 1'b1);
        no_gaps = 1'b0;
      end else if (seq_no == 6) begin
        // Let everything drain, then fill the store past its end; the
        // extra loads must be dropped and queries see all stored points.
        wait_drained();
        send_word(ntp_pkg::FN_CLEAR, pick_coord(mode, center), pick_coord(mode, center), 1'b1);
        repeat (MAX_POINTS + 4)
          send_word(ntp_pkg::FN_LOAD, pick_coord(mode, center), pick_coord(mode, center), 1'b1);
        repeat (3)
          send_word(ntp_pkg::FN_QUERY, pick_coord(mode, center), pick_coord(mode, center), 1'b1);
      end else begin
        if ($urandom_range(0, 2) == 0)
          send_word(ntp_pkg::FN_CLEAR, pick_coord(mode, center), pick_coord(mode, center), 1'b1);
        repeat ($urandom_range(0, 8))
          send_word(ntp_pkg::FN_LOAD, pick_coord(mode, center), pick_coord(mode, center), 1'b1);
        if ($urandom_range(0, 5) == 0)
          send_word(FN_UNUSED, pick_coord(COORD_FULL, 0), pick_coord(COORD_FULL, 0), 1'b1);
        repeat ($urandom_range(1, 3))
          send_word(ntp_pkg::FN_QUERY, pick_coord(mode, center), pick_coord(mode, center), 1'b1);
      end
    end

    // All words are in. Wait for every expected result, then a little longer
    // so that a stray extra word would still be caught.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && nearest_q.size() == 0 && !timed_out)
      $display("tb_nearest_three_points_top OK");
    else
      $display("tb_nearest_three_points_top NOT OK");
    $finish;
  end

endmodule
